### hw/rtl/cht_pkg.sv
package cht_pkg;

  localparam int TableSize = 256;
  localparam int IdxW      = 8;
  localparam int CntW      = 9;
  localparam int HashW     = 63;
  localparam int DataW     = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_BAD    = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       key_byte;
    logic             key_last;
    logic [DataW-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [DataW-1:0] data_out;
    logic [CntW-1:0]  entry_count;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_READ,
    ST_CHECK,
    ST_FREE,
    ST_FREE_WAIT,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/chained_hash_table.sv
// Chained hash table. Each key byte is one input transfer and is absorbed into
// the key hash. The transfer with key_last runs the request, and no further
// input transfer is taken until it is done: head and free-stack reads, then per
// chain node visited one node memory read and one hash compare (READ, CHECK),
// then a FREE step when a remove frees a node or a FREE_WAIT step when an insert
// links a new node onto a chain tail. Results sit in an output register, so
// key bytes keep flowing while a result waits; a finished request holds in its
// last state until the waiting result is taken. After reset a clearing pass
// loads the free stack with every node index before the first input transfer
// is taken. Nodes match by 63-bit hash only.
module chained_hash_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cht_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cht_pkg::out_t   out_data_o
);
  localparam int IW = cht_pkg::IdxW;
  localparam int CW = cht_pkg::CntW;
  localparam int HW = cht_pkg::HashW;
  localparam int DW = cht_pkg::DataW;

  cht_pkg::state_e state_q, state_d;

  // memories
  logic [IW-1:0] head_mem [cht_pkg::TableSize];
  logic [HW-1:0] hash_mem [cht_pkg::TableSize];
  logic [DW-1:0] data_mem [cht_pkg::TableSize];
  logic [IW:0]   next_mem [cht_pkg::TableSize];  // {valid, index}
  logic [IW-1:0] free_mem [cht_pkg::TableSize];
  logic [cht_pkg::TableSize-1:0] head_vld_q;

  logic [IW-1:0] head_rd_q, free_rd_q;
  logic [HW-1:0] hash_rd_q;
  logic [DW-1:0] data_rd_q;
  logic [IW:0]   next_rd_q;

  logic          hv_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [HW-1:0] key_q;
  logic [DW-1:0] din_q;
  logic [1:0]    req_q;
  logic [IW-1:0] cur_q, cur_d, prev_q, prev_d;
  logic          has_prev_q, has_prev_d;
  logic [CW-1:0] steps_q, steps_d;
  logic          ov_q, ov_d;
  cht_pkg::out_t res_q, res_d;
  cht_pkg::out_t out_q, out_d;

  // memory write controls
  logic          hd_we, hd_vset, hd_vclr, nx_we, hs_we, dt_we, fr_we;
  logic [IW-1:0] hd_wa, hd_wd, nx_wa, hs_wa, dt_wa, fr_wa, fr_wd;
  logic [IW:0]   nx_wd;
  logic [IW-1:0] rd_addr, fr_ra;

  logic          acc_step, acc_clear;
  logic [HW-1:0] acc_next;
  logic          take;

  cht_hash u_hash (
    .clk_i, .rst_ni,
    .step_i (acc_step),
    .clear_i(acc_clear),
    .byte_i (in_data_i.key_byte),
    .next_o (acc_next)
  );

  assign take        = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == cht_pkg::ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign acc_step    = take;
  assign acc_clear   = take && in_data_i.key_last;

  wire [IW-1:0] bkt = key_q[IW-1:0];
  wire          hit = (hash_rd_q == key_q);
  wire [IW-1:0] top = IW'(cnt_q) ^ {IW{1'b1}}; // TableSize-1-cnt

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; clr_d = clr_q; cur_d = cur_q;
    prev_d = prev_q; has_prev_d = has_prev_q; steps_d = steps_q;
    ov_d = ov_q; res_d = res_q; out_d = out_q;
    hd_we = 1'b0; hd_vset = 1'b0; hd_vclr = 1'b0; hd_wa = bkt; hd_wd = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    hs_we = 1'b0; hs_wa = '0; dt_we = 1'b0; dt_wa = '0;
    fr_we = 1'b0; fr_wa = '0; fr_wd = '0;
    rd_addr = cur_q; fr_ra = top;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      cht_pkg::ST_CLEAR: begin
        fr_we = 1'b1; fr_wa = clr_q; fr_wd = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == {IW{1'b1}}) state_d = cht_pkg::ST_IDLE;
      end
      cht_pkg::ST_IDLE: begin
        if (take && in_data_i.key_last) state_d = cht_pkg::ST_HEAD;
      end
      cht_pkg::ST_HEAD: begin
        // head and free-stack top read this cycle
        has_prev_d = 1'b0; steps_d = '0;
        state_d = cht_pkg::ST_HEAD_WAIT;
      end
      cht_pkg::ST_HEAD_WAIT: begin
        cur_d = head_rd_q;
        res_d = '0; res_d.entry_count = cnt_q;
        if (req_q == cht_pkg::REQ_BAD) begin
          res_d.status = 1'b1; state_d = cht_pkg::ST_DONE;
        end else if (req_q == cht_pkg::REQ_INSERT && cnt_q[CW-1]) begin
          res_d.status = 1'b1; state_d = cht_pkg::ST_DONE;
        end else if (req_q == cht_pkg::REQ_REMOVE && cnt_q == '0) begin
          res_d.status = 1'b1; state_d = cht_pkg::ST_DONE;
        end else if (!hv_q) begin
          if (req_q == cht_pkg::REQ_INSERT) begin
            hs_we = 1'b1; hs_wa = free_rd_q; dt_we = 1'b1; dt_wa = free_rd_q;
            nx_we = 1'b1; nx_wa = free_rd_q; nx_wd = '0;
            hd_we = 1'b1; hd_vset = 1'b1; hd_wd = free_rd_q;
            cnt_d = cnt_q + 1'b1; res_d.entry_count = cnt_q + 1'b1;
          end
          state_d = cht_pkg::ST_DONE;
        end else begin
          state_d = cht_pkg::ST_READ;
        end
      end
      cht_pkg::ST_READ: begin
        state_d = cht_pkg::ST_CHECK;
      end
      cht_pkg::ST_CHECK: begin
        if (hit) begin
          unique case (req_q)
            cht_pkg::REQ_INSERT: begin
              dt_we = 1'b1; dt_wa = cur_q;
              state_d = cht_pkg::ST_DONE;
            end
            cht_pkg::REQ_REMOVE: begin
              if (has_prev_q) begin
                nx_we = 1'b1; nx_wa = prev_q; nx_wd = next_rd_q;
              end else begin
                hd_we = 1'b1; hd_wd = next_rd_q[IW-1:0];
                hd_vset = next_rd_q[IW]; hd_vclr = !next_rd_q[IW];
              end
              cnt_d = cnt_q - 1'b1; res_d.entry_count = cnt_q - 1'b1;
              state_d = cht_pkg::ST_FREE;
            end
            default: begin
              res_d.found = 1'b1; res_d.data_out = data_rd_q;
              state_d = cht_pkg::ST_DONE;
            end
          endcase
        end else if (!next_rd_q[IW] || steps_q + 1'b1 >= CW'(cht_pkg::TableSize)) begin
          if (req_q == cht_pkg::REQ_INSERT) begin
            hs_we = 1'b1; hs_wa = free_rd_q; dt_we = 1'b1; dt_wa = free_rd_q;
            nx_we = 1'b1; nx_wa = free_rd_q; nx_wd = '0;
            // second next write lands on tail the next cycle
            state_d = cht_pkg::ST_FREE_WAIT;
            cnt_d = cnt_q + 1'b1; res_d.entry_count = cnt_q + 1'b1;
          end else begin
            state_d = cht_pkg::ST_DONE;
          end
        end else begin
          prev_d = cur_q; has_prev_d = 1'b1;
          cur_d = next_rd_q[IW-1:0]; steps_d = steps_q + 1'b1;
          state_d = cht_pkg::ST_READ;
        end
      end
      cht_pkg::ST_FREE_WAIT: begin
        // link tail to the new node
        nx_we = 1'b1; nx_wa = cur_q; nx_wd = {1'b1, free_rd_q};
        state_d = cht_pkg::ST_DONE;
      end
      cht_pkg::ST_FREE: begin
        fr_we = 1'b1; fr_wa = top; fr_wd = cur_q;
        state_d = cht_pkg::ST_DONE;
      end
      cht_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; out_d = res_q; state_d = cht_pkg::ST_IDLE;
        end
      end
      default: state_d = cht_pkg::ST_IDLE;
    endcase
  end

  // capture request on the final key byte
  always_ff @(posedge clk_i) begin
    if (acc_clear) begin
      key_q <= acc_next; req_q <= in_data_i.req_type; din_q <= in_data_i.data_in;
    end
  end

  // memory ports, registered reads
  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (hs_we) hash_mem[hs_wa] <= key_q;
    if (dt_we) data_mem[dt_wa] <= din_q;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (fr_we) free_mem[fr_wa] <= fr_wd;
    head_rd_q <= head_mem[bkt];
    free_rd_q <= free_mem[fr_ra];
    hash_rd_q <= hash_mem[rd_addr];
    data_rd_q <= data_mem[rd_addr];
    next_rd_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::ST_CLEAR; cnt_q <= '0; clr_q <= '0; ov_q <= 1'b0;
      head_vld_q <= '0; hv_q <= 1'b0; cur_q <= '0; prev_q <= '0;
      has_prev_q <= 1'b0; steps_q <= '0; res_q <= '0; out_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; clr_q <= clr_d; ov_q <= ov_d;
      cur_q <= cur_d; prev_q <= prev_d; has_prev_q <= has_prev_d;
      steps_q <= steps_d; res_q <= res_d; out_q <= out_d;
      hv_q <= head_vld_q[bkt];
      if (hd_we && hd_vset) head_vld_q[hd_wa] <= 1'b1;
      if (hd_we && hd_vclr) head_vld_q[hd_wa] <= 1'b0;
    end
  end
endmodule

### hw/rtl/cht_hash.sv
// Polynomial key hash: h = 31*h + byte, kept to 63 bits.
module cht_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     clear_i,
  input  logic [7:0]               byte_i,
  output logic [cht_pkg::HashW-1:0] next_o
);
  logic [cht_pkg::HashW-1:0] acc_q, acc_d;

  // 31*h is a shift and subtract
  assign next_o = (acc_q << 5) - acc_q + {55'd0, byte_i};

  always_comb begin
    acc_d = acc_q;
    if (step_i) acc_d = next_o;
    if (clear_i) acc_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end
endmodule

### hw/rtl/cht_checker.sv
// Port-level checks for the chained hash table.
module cht_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input cht_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cht_pkg::out_t out_data_o
);
  // a result waits until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed");

  // a final key byte never meets an immediate result
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.key_last |=> !in_ready_o)
    else $error("ready after final key byte");

  // found only on accepted requests
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> !out_data_o.status)
    else $error("found with reject");

  // count stays in range
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= 9'd256)
    else $error("count out of range");
endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);

### tb/sv/tb_chained_hash_table.sv
`timescale 1ns / 1ps

module tb_chained_hash_table;
  import cht_pkg::*;

  typedef logic [7:0] key_q_t[$];

  typedef struct {
    in_t  item;
    bit   typed;
    out_t exp;
  } row_t;

  typedef struct {
    bit   typed;
    out_t exp;
  } tag_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  chained_hash_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Shadow table
  logic [HashW-1:0] acc_hash;
  logic             head_ok [TableSize];
  logic [IdxW-1:0]  head_idx[TableSize];
  logic [HashW-1:0] node_hash[TableSize];
  logic [DataW-1:0] node_data[TableSize];
  logic             link_ok [TableSize];
  logic [IdxW-1:0]  link_idx[TableSize];
  logic [IdxW-1:0]  free_stack[TableSize];
  int unsigned      live_count;

  out_t expected_q[$];
  tag_t tag_q[$];
  bit   failed;
  bit   no_idle;
  int   items_sent;
  int   results_seen;

  function automatic void shadow_reset();
    acc_hash = '0;
    live_count = 0;
    for (int i = 0; i < TableSize; i++) begin
      head_ok[i]    = 1'b0;
      head_idx[i]   = '0;
      node_hash[i]  = '0;
      node_data[i]  = '0;
      link_ok[i]    = 1'b0;
      link_idx[i]   = '0;
      free_stack[i] = i[IdxW-1:0];
    end
  endfunction

  // Search bucket b for hash h; hit is the match or the tail node
  function automatic bit chain_search(int b, logic [HashW-1:0] h, output logic [IdxW-1:0] hit,
                                      output logic [IdxW-1:0] prev, output bit has_prev);
    logic [IdxW-1:0] cur;
    cur = head_idx[b];
    has_prev = 1'b0;
    prev = '0;
    for (int steps = 0; ; steps++) begin
      if (node_hash[cur] == h) begin
        hit = cur;
        return 1'b1;
      end
      if (!link_ok[cur] || steps + 1 >= TableSize) begin
        hit = cur;
        return 1'b0;
      end
      prev = cur;
      has_prev = 1'b1;
      cur = link_idx[cur];
    end
  endfunction

  // Absorb one key byte; on the final byte run the request
  function automatic bit table_step(in_t it, output out_t res);
    logic [HashW-1:0] h;
    logic [63:0]      prod;
    logic [IdxW-1:0]  hit, prev, n;
    bit               has_prev, match;
    int               b;
    prod = 64'(acc_hash) * 64'd31 + 64'(it.key_byte);
    acc_hash = prod[HashW-1:0];
    res = '0;
    if (!it.key_last) return 1'b0;
    h = acc_hash;
    acc_hash = '0;
    b = int'(h[IdxW-1:0]);
    case (req_e'(it.req_type))
      REQ_INSERT: begin
        if (live_count >= TableSize) begin
          res.status = 1'b1;
        end else begin
          match = head_ok[b] && chain_search(b, h, hit, prev, has_prev);
          if (match) begin
            node_data[hit] = it.data_in;
          end else begin
            n = free_stack[TableSize - 1 - live_count];
            node_hash[n] = h;
            node_data[n] = it.data_in;
            link_ok[n]   = 1'b0;
            link_idx[n]  = '0;
            if (head_ok[b]) begin
              link_ok[hit]  = 1'b1;
              link_idx[hit] = n;
            end else begin
              head_ok[b]  = 1'b1;
              head_idx[b] = n;
            end
            live_count++;
          end
        end
      end
      REQ_REMOVE: begin
        if (live_count == 0) begin
          res.status = 1'b1;
        end else if (head_ok[b] && chain_search(b, h, hit, prev, has_prev)) begin
          if (has_prev) begin
            link_ok[prev]  = link_ok[hit];
            link_idx[prev] = link_idx[hit];
          end else begin
            head_ok[b]  = link_ok[hit];
            head_idx[b] = link_idx[hit];
          end
          live_count--;
          free_stack[TableSize - 1 - live_count] = hit;
        end
      end
      REQ_GET: begin
        if (live_count != 0 && head_ok[b] && chain_search(b, h, hit, prev, has_prev)) begin
          res.found    = 1'b1;
          res.data_out = node_data[hit];
        end
      end
      default: res.status = 1'b1;
    endcase
    res.entry_count = CntW'(live_count);
    return 1'b1;
  endfunction

  // Predict on every accepted input transfer
  always @(posedge clk_i) begin
    out_t res;
    tag_t tg;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (table_step(in_data_i, res)) begin
        tg = tag_q.pop_front();
        expected_q.push_back(tg.typed ? tg.exp : res);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data_o.status);
          failed = 1'b1;
        end
        if (out_data_o.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_data_o.found);
          failed = 1'b1;
        end
        if (out_data_o.data_out !== e.data_out) begin
          $error("data_out: expected %h, got %h", e.data_out, out_data_o.data_out);
          failed = 1'b1;
        end
        if (out_data_o.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, out_data_o.entry_count);
          failed = 1'b1;
        end
      end
    end
  end

  // Result side: random stalls per transfer, one long hold-off mid run
  int rx_wait;
  int rx_hold;
  bit hold_used;
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait <= 0;
      rx_hold <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && results_seen == 350) begin
      hold_used <= 1'b1;
      rx_hold <= 600;
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= (rx_hold == 1);
    end else if (out_valid_o && out_ready_i) begin
      r = no_idle ? 0 : $urandom_range(0, 13);
      rx_wait <= r;
      out_ready_i <= (r == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready_i <= (rx_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Run limit
  int cycles;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive one transfer, hold until accepted, then idle a random gap
  task automatic send_item(in_t it, bit typed, out_t exp);
    int gap;
    tag_t tg;
    if (it.key_last) begin
      tg.typed = typed;
      tg.exp = exp;
      tag_q.push_back(tg);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stream a whole key; only the final byte carries the real request
  task automatic send_key(req_e rq, key_q_t k, logic [DataW-1:0] data);
    in_t it;
    for (int i = 0; i < k.size(); i++) begin
      it.key_last = (i == k.size() - 1);
      it.req_type = it.key_last ? rq : 2'($urandom_range(0, 3));
      it.key_byte = k[i];
      it.data_in  = it.key_last ? data : $urandom;
      send_item(it, 1'b0, '0);
    end
  endtask

  function automatic req_e pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_INSERT;
    if (r < 70) return REQ_REMOVE;
    if (r < 95) return REQ_GET;
    return REQ_BAD;
  endfunction

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (expected_q.size() == 0 && tag_q.size() == 0);
    @(posedge clk_i);
  endtask

  key_q_t          pool[64];
  logic [15:0]     filled[$];

  // Directed rows: empty table, extremes, bad code, bucket collision 0x05 vs {0x01,0xE6}
  row_t dir_rows[] = '{
    '{'{REQ_GET,    8'h41, 1'b1, 32'h0},        1'b1, '{1'b0, 1'b0, 32'h0, 9'd0}},
    '{'{REQ_REMOVE, 8'h41, 1'b1, 32'h0},        1'b1, '{1'b1, 1'b0, 32'h0, 9'd0}},
    '{'{REQ_BAD,    8'hFF, 1'b1, 32'hFFFFFFFF}, 1'b1, '{1'b1, 1'b0, 32'h0, 9'd0}},
    '{'{REQ_INSERT, 8'h00, 1'b1, 32'hFFFFFFFF}, 1'b1, '{1'b0, 1'b0, 32'h0, 9'd1}},
    '{'{REQ_GET,    8'h00, 1'b1, 32'h0},        1'b1, '{1'b0, 1'b1, 32'hFFFFFFFF, 9'd1}},
    '{'{REQ_INSERT, 8'h05, 1'b1, 32'h00001234}, 1'b1, '{1'b0, 1'b0, 32'h0, 9'd2}},
    '{'{REQ_BAD,    8'h01, 1'b0, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{REQ_INSERT, 8'hE6, 1'b1, 32'h00005678}, 1'b1, '{1'b0, 1'b0, 32'h0, 9'd3}},
    '{'{REQ_INSERT, 8'h01, 1'b0, 32'h0},        1'b0, '0},
    '{'{REQ_GET,    8'hE6, 1'b1, 32'h0},        1'b1, '{1'b0, 1'b1, 32'h00005678, 9'd3}},
    '{'{REQ_GET,    8'h05, 1'b1, 32'h0},        1'b0, '0},
    '{'{REQ_INSERT, 8'h05, 1'b1, 32'h0000AAAA}, 1'b0, '0},
    '{'{REQ_GET,    8'h05, 1'b1, 32'h0},        1'b0, '0},
    '{'{REQ_REMOVE, 8'h05, 1'b1, 32'h0},        1'b0, '0},
    '{'{REQ_GET,    8'h01, 1'b0, 32'h0},        1'b0, '0},
    '{'{REQ_GET,    8'hE6, 1'b1, 32'h0},        1'b0, '0},
    '{'{REQ_REMOVE, 8'h01, 1'b0, 32'h0},        1'b0, '0},
    '{'{REQ_REMOVE, 8'hE6, 1'b1, 32'h0},        1'b0, '0},
    '{'{REQ_REMOVE, 8'hFF, 1'b1, 32'h0},        1'b1, '{1'b0, 1'b0, 32'h0, 9'd1}},
    '{'{REQ_REMOVE, 8'h00, 1'b1, 32'h0},        1'b1, '{1'b0, 1'b0, 32'h0, 9'd0}},
    '{'{REQ_GET,    8'h00, 1'b1, 32'h0},        1'b1, '{1'b0, 1'b0, 32'h0, 9'd0}}
  };

  initial begin
    int n;
    key_q_t k;
    failed = 1'b0;
    no_idle = 1'b0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    shadow_reset();
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Key pool: short keys, crafted bucket collisions, and long keys that wrap the hash
    for (int i = 0; i < 64; i++) begin
      pool[i] = {};
      if (i >= 8 && i < 16) begin
        pool[i].push_back(8'h01);
        pool[i].push_back(pool[i - 8][0] - 8'd31);
      end else begin
        n = (i < 8) ? 1 : (i < 56) ? $urandom_range(1, 3) : $urandom_range(14, 20);
        for (int j = 0; j < n; j++) pool[i].push_back(8'($urandom));
      end
    end

    // Directed part
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);

    // Mixed traffic on the pool
    for (int i = 0; i < 40; i++)
      send_key(pick_req(), pool[$urandom_range(0, 63)], $urandom);

    // Fill past capacity with fresh two-byte keys
    n = 0;
    while (n < 20) begin
      k = {8'($urandom), 8'($urandom)};
      if (live_count >= TableSize) n++;
      else filled.push_back({k[0], k[1]});
      send_key(REQ_INSERT, k, $urandom);
    end
    send_key(REQ_INSERT, pool[0], 32'h0);
    drain_wait();

    // Remove the filled keys (some are only looked up) and every pool key
    foreach (filled[i]) begin
      k = {filled[i][15:8], filled[i][7:0]};
      send_key($urandom_range(0, 3) == 0 ? REQ_GET : REQ_REMOVE, k, $urandom);
    end
    for (int i = 0; i < 64; i++) send_key(REQ_REMOVE, pool[i], $urandom);
    send_key(REQ_GET, pool[1], 32'h0);

    // More mixed traffic, with a stretch of no idling on either side
    n = 0;
    while (items_sent < 1600) begin
      no_idle = (n >= 10 && n < 30);
      send_key(pick_req(), pool[$urandom_range(0, 63)], $urandom);
      n++;
    end
    no_idle = 1'b0;

    drain_wait();
    repeat (50) @(posedge clk_i);
    if (expected_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
